@@ rtl/sed_pkg.sv @@
// ----------------------------------------------------------------------------
// sed_pkg
// shared constants and helpers for the string escape decoder
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned StatW = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [StatW-1:0] stat_t;

  localparam stat_t StByte   = 2'd0;
  localparam stat_t StAccept = 2'd1;
  localparam stat_t StReject = 2'd2;

  localparam byte_t ChQuote = 8'h22;
  localparam byte_t ChBslash = 8'h5c;
  localparam byte_t ChLowN = 8'h6e;
  localparam byte_t ChLowR = 8'h72;
  localparam byte_t ChLowF = 8'h66;
  localparam byte_t ChLowB = 8'h62;
  localparam byte_t ChLowT = 8'h74;
  localparam byte_t ChLowX = 8'h78;
  localparam byte_t ChZero = 8'h30;
  localparam byte_t ChSeven = 8'h37;
  localparam byte_t ChNine = 8'h39;
  localparam byte_t ChLowA = 8'h61;
  localparam byte_t ChUpA = 8'h41;
  localparam byte_t CodeNl = 8'h0a;
  localparam byte_t CodeCr = 8'h0d;
  localparam byte_t CodeFf = 8'h0c;
  localparam byte_t CodeBs = 8'h08;
  localparam byte_t CodeTab = 8'h09;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input byte_t c);
    hex_t  h;
    byte_t d;
    h = '0;
    d = '0;
    if (c >= ChZero && c <= ChNine) begin
      d     = c - ChZero;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end else if (c >= ChLowA && c <= ChLowA + 8'd5) begin
      d     = c - ChLowA + 8'd10;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end else if (c >= ChUpA && c <= ChUpA + 8'd5) begin
      d     = c - ChUpA + 8'd10;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end
    return h;
  endfunction

endpackage

@@ rtl/string_escape_decoder.sv @@
// ----------------------------------------------------------------------------
// string_escape_decoder
// decodes one double-quoted string literal with backslash escapes
// ----------------------------------------------------------------------------
// Raw bytes of a literal enter on the in_ stream, quotes included, with
// in_tlast on the closing byte. Each decoded content byte leaves on the
// out_ stream with out_tuser = byte status; the closing byte gives one
// transaction with status accept or reject and zero data. Opening quote,
// backslash and non-last escape digits give no transaction.
// A result is registered into the output register, or into the skid
// register while the receiver stalls. Throughput: one byte per cycle
// while in_tready is high; the decode is a single pass from the input
// port and the phase register into the result register.
// A skid register behind the output register lets one more transaction
// be taken while the receiver stalls; in_tready drops only when both are
// full, and rises again as soon as the receiver takes a result.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to waiting for an opening quote.
module string_escape_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  sed_pkg::byte_t       in_tdata,   // [7:0] in_char
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output sed_pkg::byte_t       out_tdata,  // [7:0] out_byte
  output sed_pkg::stat_t       out_tuser   // [1:0] status
);
  import sed_pkg::*;

  typedef enum logic [3:0] {
    PH_OPEN = 4'd0,
    PH_BODY = 4'd1,
    PH_ESC  = 4'd2,
    PH_HEX1 = 4'd3,
    PH_HEX2 = 4'd4,
    PH_OCT1 = 4'd5,
    PH_OCT2 = 4'd6,
    PH_OCT3 = 4'd7,
    PH_ERR  = 4'd8
  } phase_t;

  phase_t phase_r, phase_nxt;
  byte_t  pv_r, pv_nxt;
  logic   emit;
  byte_t  res_byte;
  stat_t  res_stat;
  hex_t   hd;
  logic   oct_ok;

  logic   out_vld_r, skid_vld_r;
  byte_t  out_byte_r, skid_byte_r;
  stat_t  out_stat_r, skid_stat_r;
  logic   in_fire, out_fire;

  assign in_tready  = !skid_vld_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_vld_r && out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_stat_r;

  assign hd     = hex_digit(in_tdata);
  assign oct_ok = (in_tdata >= ChZero) && (in_tdata <= ChSeven);

  always_comb begin
    phase_nxt = phase_r;
    pv_nxt    = pv_r;
    emit      = 1'b0;
    res_byte  = '0;
    res_stat  = StByte;
    if (in_tlast) begin
      phase_nxt = PH_OPEN;
      pv_nxt    = '0;
      emit      = 1'b1;
      res_stat  = (phase_r == PH_BODY && in_tdata == ChQuote) ? StAccept : StReject;
    end else begin
      case (phase_r)
        PH_OPEN: begin
          phase_nxt = (in_tdata == ChQuote) ? PH_BODY : PH_ERR;
        end
        PH_BODY: begin
          if (in_tdata == ChBslash) begin
            phase_nxt = PH_ESC;
          end else begin
            emit     = 1'b1;
            res_byte = in_tdata;
          end
        end
        PH_ESC: begin
          phase_nxt = PH_BODY;
          emit      = 1'b1;
          case (in_tdata)
            ChLowN:  res_byte = CodeNl;
            ChLowR:  res_byte = CodeCr;
            ChLowF:  res_byte = CodeFf;
            ChLowB:  res_byte = CodeBs;
            ChLowT:  res_byte = CodeTab;
            ChQuote: res_byte = ChQuote;
            ChBslash: res_byte = ChBslash;
            ChLowX: begin
              emit      = 1'b0;
              pv_nxt    = '0;
              phase_nxt = PH_HEX1;
            end
            ChZero: begin
              emit      = 1'b0;
              pv_nxt    = '0;
              phase_nxt = PH_OCT1;
            end
            default: begin
              emit      = 1'b0;
              phase_nxt = PH_ERR;
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (!hd.ok) begin
            phase_nxt = PH_ERR;
          end else begin
            pv_nxt = {pv_r[3:0], hd.val};
            if (phase_r == PH_HEX1) begin
              phase_nxt = PH_HEX2;
            end else begin
              phase_nxt = PH_BODY;
              emit      = 1'b1;
              res_byte  = pv_nxt;
            end
          end
        end
        PH_OCT1, PH_OCT2, PH_OCT3: begin
          if (!oct_ok) begin
            phase_nxt = PH_ERR;
          end else begin
            pv_nxt = {pv_r[4:0], in_tdata[2:0]};
            case (phase_r)
              PH_OCT1: phase_nxt = PH_OCT2;
              PH_OCT2: phase_nxt = PH_OCT3;
              default: begin
                phase_nxt = PH_BODY;
                emit      = 1'b1;
                res_byte  = pv_nxt;
              end
            endcase
          end
        end
        default: begin
          phase_nxt = PH_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OPEN;
      pv_r       <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        pv_r    <= pv_nxt;
      end
      if (skid_vld_r) begin
        if (out_fire) begin
          out_byte_r <= skid_byte_r;
          out_stat_r <= skid_stat_r;
          skid_vld_r <= 1'b0;
        end
      end else if (in_fire && emit) begin
        if (!out_vld_r || out_tready) begin
          out_vld_r  <= 1'b1;
          out_byte_r <= res_byte;
          out_stat_r <= res_stat;
        end else begin
          skid_vld_r  <= 1'b1;
          skid_byte_r <= res_byte;
          skid_stat_r <= res_stat;
        end
      end else if (out_fire) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/sed_checker.sv @@
// ----------------------------------------------------------------------------
// sed_checker
// port-level checks for the string escape decoder
// ----------------------------------------------------------------------------
module sed_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_tvalid,
  input logic           in_tready,
  input logic           in_tlast,
  input logic           out_tvalid,
  input logic           out_tready,
  input sed_pkg::byte_t out_tdata,
  input sed_pkg::stat_t out_tuser
);
  import sed_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // end-of-literal statuses carry zero data
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == StAccept || out_tuser == StReject) |-> out_tdata == '0)
    else $error("end status with nonzero data");

  // closing byte into an idle output shows its end status next cycle
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && !out_tvalid |=>
      out_tvalid && (out_tuser == StAccept || out_tuser == StReject))
    else $error("closing byte gave no end status");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output not empty after reset");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the string escape decoder
// ----------------------------------------------------------------------------
// Sends whole quoted literals byte by byte, with tlast on the closing byte.
// It starts with a few hand-built literals: every escape letter, hex and
// octal escapes, raw extreme bytes, and each way a literal can be rejected.
// Random literals follow. Most are well formed with random content. About
// one in five is broken: a byte overwritten, the literal cut short, a bad
// closing byte, or plain noise. A scoreboard decodes every accepted byte
// and compares each result transaction in order. Both sides insert random
// gaps, and the sender drains the decoder once in the middle of the run.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sed_pkg::*;

  class escape_scoreboard;
    typedef enum logic [3:0] {
      PhOpen, PhBody, PhEsc, PhHex1, PhHex2, PhOct1, PhOct2, PhOct3, PhErr
    } phase_t;

    typedef struct packed {
      byte_t data;
      stat_t status;
    } decoded_t;

    phase_t   phase;
    byte_t    partial;
    decoded_t decoded_q[$];
    int       mismatches;
    int       n_bytes;
    int       n_accept;
    int       n_reject;

    function new();
      phase      = PhOpen;
      partial    = '0;
      mismatches = 0;
      n_bytes    = 0;
      n_accept   = 0;
      n_reject   = 0;
    endfunction

    function int hex_value(byte_t c);
      if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
      if (c >= ChLowA && c <= ChLowA + 8'd5) return int'(c - ChLowA) + 10;
      if (c >= ChUpA && c <= ChUpA + 8'd5) return int'(c - ChUpA) + 10;
      return -1;
    endfunction

    function void push(byte_t d, stat_t s);
      decoded_t e;
      e.data    = d;
      e.status  = s;
      decoded_q = {decoded_q, e};
    endfunction

    function void decode_char(byte_t c, logic fin);
      int d;
      if (fin) begin
        push(8'h00, (phase == PhBody && c == ChQuote) ? StAccept : StReject);
        phase   = PhOpen;
        partial = '0;
        return;
      end
      case (phase)
        PhOpen: phase = (c == ChQuote) ? PhBody : PhErr;
        PhBody: begin
          if (c == ChBslash) phase = PhEsc;
          else push(c, StByte);
        end
        PhEsc: begin
          phase = PhBody;
          case (c)
            ChLowN: push(CodeNl, StByte);
            ChLowR: push(CodeCr, StByte);
            ChLowF: push(CodeFf, StByte);
            ChLowB: push(CodeBs, StByte);
            ChLowT: push(CodeTab, StByte);
            ChQuote, ChBslash: push(c, StByte);
            ChLowX: begin
              partial = '0;
              phase   = PhHex1;
            end
            ChZero: begin
              partial = '0;
              phase   = PhOct1;
            end
            default: phase = PhErr;
          endcase
        end
        PhHex1, PhHex2: begin
          d = hex_value(c);
          if (d < 0) begin
            phase = PhErr;
          end else begin
            partial = {partial[3:0], 4'(d)};
            if (phase == PhHex1) begin
              phase = PhHex2;
            end else begin
              phase = PhBody;
              push(partial, StByte);
            end
          end
        end
        PhOct1, PhOct2, PhOct3: begin
          if (c < ChZero || c > ChSeven) begin
            phase = PhErr;
          end else begin
            // value keeps only its low 8 bits
            partial = {partial[4:0], c[2:0]};
            case (phase)
              PhOct1: phase = PhOct2;
              PhOct2: phase = PhOct3;
              default: begin
                phase = PhBody;
                push(partial, StByte);
              end
            endcase
          end
        end
        default: phase = PhErr;
      endcase
    endfunction

    function void compare_output(byte_t d, stat_t s);
      decoded_t e;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: data %h status %0d", d, s);
        return;
      end
      e = decoded_q.pop_front();
      if (d !== e.data || s !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: data %h (expected %h), status %0d (expected %0d)",
                   d, e.data, s, e.status);
      end
      case (e.status)
        StByte:   n_bytes++;
        StAccept: n_accept++;
        default:  n_reject++;
      endcase
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_tvalid;
  logic  in_tready;
  byte_t in_tdata;
  logic  in_tlast;
  logic  out_tvalid;
  logic  out_tready;
  byte_t out_tdata;
  stat_t out_tuser;

  escape_scoreboard escape_sb = new();

  byte_t lit[$];
  byte_t esc_letters[7] = '{ChLowN, ChLowR, ChLowF, ChLowB, ChLowT, ChQuote, ChBslash};
  int    sent_bytes;
  int    sent_lits;
  int    in_calm;
  int    out_calm;
  bit    drained;

  string_escape_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] in_char
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [7:0] out_byte
    .out_tuser (out_tuser)   // [1:0] status
  );

  always #5 clk = ~clk;

  // random gap, with occasional runs of back-to-back transactions
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 10);
  endfunction

  function automatic byte_t hex_char(int v);
    if (v < 10) return ChZero + byte_t'(v);
    return ($urandom_range(0, 1) ? ChLowA : ChUpA) + byte_t'(v - 10);
  endfunction

  task automatic push_byte(byte_t c, logic fin);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    escape_sb.decode_char(c, fin);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_lit();
    foreach (lit[i]) push_byte(lit[i], i == lit.size() - 1);
    sent_lits++;
  endtask

  task automatic drain_decoder();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (escape_sb.pending() != 0);
  endtask

  task automatic build_random_lit();
    int    n;
    int    k;
    int    pos;
    byte_t c;
    lit = {ChQuote};
    n = $urandom_range(0, 12);
    repeat (n) begin
      k = $urandom_range(0, 9);
      if (k <= 4) begin
        c = byte_t'($urandom_range(0, 255));
        if (c == ChBslash) c = ChQuote;
        lit = {lit, c};
      end else if (k == 5) begin
        lit = {lit, ChBslash, esc_letters[$urandom_range(0, 6)]};
      end else if (k <= 7) begin
        lit = {lit, ChBslash, ChLowX};
        lit = {lit, hex_char($urandom_range(0, 15))};
        lit = {lit, hex_char($urandom_range(0, 15))};
      end else begin
        lit = {lit, ChBslash, ChZero};
        repeat (3) lit = {lit, byte_t'(ChZero + byte_t'($urandom_range(0, 7)))};
      end
    end
    lit = {lit, ChQuote};
    // roughly one literal in five gets broken
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, 3);
      if (k == 0) begin
        lit[$urandom_range(0, lit.size() - 1)] = byte_t'($urandom_range(0, 255));
      end else if (k == 1) begin
        pos = $urandom_range(1, lit.size());
        lit = lit[0:pos-1];
      end else if (k == 2) begin
        lit[lit.size() - 1] = byte_t'($urandom_range(0, 255));
      end else begin
        n   = $urandom_range(1, 8);
        lit = {};
        repeat (n) lit = {lit, byte_t'($urandom_range(0, 255))};
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      escape_sb.compare_output(out_tdata, out_tuser);
  end

  initial begin
    int gap;
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    in_calm    = 0;
    out_calm   = 0;
    sent_bytes = 0;
    sent_lits  = 0;
    drained    = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // all escapes, mixed-case hex, octal overflow, raw extremes, bare quote
    lit = {ChQuote, ChBslash, ChLowN, ChBslash, ChLowR, ChBslash, ChLowF,
           ChBslash, ChLowB, ChBslash, ChLowT, ChBslash, ChQuote, ChBslash, ChBslash,
           ChBslash, ChLowX, ChUpA, ChLowF, ChBslash, ChZero, ChSeven, ChSeven, ChSeven,
           8'h00, 8'hff, ChQuote, ChQuote};
    send_lit();
    // bad opening byte
    lit = {ChLowX, ChQuote};
    send_lit();
    // too short
    lit = {ChQuote};
    send_lit();
    // unknown escape letter
    lit = {ChQuote, ChBslash, 8'h71, ChQuote};
    send_lit();
    // bad hex digit
    lit = {ChQuote, ChBslash, ChLowX, 8'h67, ChQuote};
    send_lit();
    // bad octal digit
    lit = {ChQuote, ChBslash, ChZero, 8'h38, ChQuote};
    send_lit();
    // escape cut off by the closing quote
    lit = {ChQuote, ChBslash, ChQuote};
    send_lit();
    // closing byte is not a quote
    lit = {ChQuote, ChLowA, 8'h27};
    send_lit();

    while (sent_bytes < 1250) begin
      build_random_lit();
      send_lit();
      if (!drained && sent_bytes >= 625) begin
        drain_decoder();
        drained = 1'b1;
      end
    end
    drain_decoder();
    repeat (10) @(negedge clk);

    $display("sent %0d bytes in %0d literals", sent_bytes, sent_lits);
    $display("checked %0d decoded bytes, %0d accepted and %0d rejected literals",
             escape_sb.n_bytes, escape_sb.n_accept, escape_sb.n_reject);
    if (escape_sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", escape_sb.mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout, %0d transactions outstanding", escape_sb.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule
